FILE: src/mdt_pkg.sv
package mdt_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned OpW    = 3;

  localparam logic [CountW-1:0] TickMax = 16'hFFFF;

  localparam logic [OpW-1:0] OpTick    = 3'd0;
  localparam logic [OpW-1:0] OpStart   = 3'd1;
  localparam logic [OpW-1:0] OpStop    = 3'd2;
  localparam logic [OpW-1:0] OpExpired = 3'd3;
  localparam logic [OpW-1:0] OpRunning = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] delay_ticks;
  } mdt_in_t;

  typedef struct packed {
    logic expired;
    logic running;
  } mdt_out_t;

  typedef struct packed {
    logic     has_result;
    mdt_out_t result;
  } mdt_core_rsp_t;

endpackage

FILE: src/mdt_timer_core.sv
module mdt_timer_core #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  mdt_pkg::mdt_in_t      item_i,
  output mdt_pkg::mdt_core_rsp_t rsp_o
);
  import mdt_pkg::*;

  localparam int unsigned Reach = 1 << SlotW;
  localparam int unsigned Depth = (NUM_SLOTS < Reach) ? NUM_SLOTS : Reach;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [SlotW:0] DepthLim = (SlotW + 1)'(Depth);

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] slots_q [Depth];

  logic              slot_ok;
  logic [IdxW-1:0]   idx;
  logic [CountW-1:0] stamp;
  logic [CountW-1:0] elapsed;
  logic              wrapped;
  logic              is_expired;
  logic              wr_en;
  logic [CountW-1:0] wr_data;

  assign slot_ok = {1'b0, item_i.slot} < DepthLim;
  assign idx     = item_i.slot[IdxW-1:0];
  assign stamp   = slot_ok ? slots_q[idx] : '0;
  assign wrapped = stamp > count_q;
  assign elapsed = count_q - stamp - {{(CountW-1){1'b0}}, wrapped};
  assign is_expired = slot_ok && (elapsed > item_i.delay_ticks);

  always_comb begin
    count_d         = count_q;
    wr_en           = 1'b0;
    wr_data         = '0;
    rsp_o           = '0;
    case (item_i.operation)
      OpTick: begin
        count_d = (count_q == TickMax) ? {{(CountW-1){1'b0}}, 1'b1} : count_q + 1'b1;
      end
      OpStart: begin
        wr_en   = slot_ok;
        wr_data = count_q;
      end
      OpStop: begin
        wr_en = slot_ok;
      end
      OpExpired: begin
        rsp_o.has_result     = 1'b1;
        rsp_o.result.expired = is_expired;
        wr_en                = is_expired;
      end
      OpRunning: begin
        rsp_o.has_result     = 1'b1;
        rsp_o.result.running = slot_ok && (stamp != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < Depth; i++) begin
        slots_q[i] <= '0;
      end
    end else if (en_i) begin
      count_q <= count_d;
      if (wr_en) begin
        slots_q[idx] <= wr_data;
      end
    end
  end

endmodule

FILE: src/multi_slot_delay_timer.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i   (operation, slot, delay_ticks)
// out      output     out_valid_o / out_stall_i out_data_o  (expired, running)
//
// One item per cycle when not stalled: an accepted beat is registered, then executed
// against the counter and slot registers; a query result lands in the output register
// at the end of the cycle in which it executes. Tick, start, stop and unused codes produce no beat.
// Reset clears the counter, all slots and both stages at once.
// A query waits in the input stage only while a result is held under out_stall_i.
module multi_slot_delay_timer #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mdt_pkg::mdt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mdt_pkg::mdt_out_t out_data_o
);
  import mdt_pkg::*;

  logic          s1_valid_q;
  mdt_in_t       s1_q;
  logic          out_valid_q;
  mdt_out_t      out_q;
  mdt_core_rsp_t rsp;
  logic          out_free;
  logic          s1_go;
  logic          accept;

  mdt_timer_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (s1_go),
    .item_i(s1_q),
    .rsp_o (rsp)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!rsp.has_result || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && rsp.has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && rsp.has_result) begin
      out_q <= rsp.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
